@@ rtl/lpd_pkg.sv @@
// Shared constants, types and helper functions of the LT peeling decoder.
package lpd_pkg;

	localparam int SRC = 64;
	localparam int SB = 64;
	localparam int BUF = 128;
	localparam int DEG_OFF = 0;
	localparam int MASK_OFF = 6;
	localparam int MASK_BYTES = (SRC + 7) / 8;
	localparam int PAY_OFF = MASK_OFF + MASK_BYTES;
	localparam int POS_CAP = PAY_OFF + SB + DEG_OFF + 1;

	localparam int SRCW = $clog2(SRC);
	localparam int SRCCW = $clog2(SRC + 1);
	localparam int ENTW = $clog2(BUF);
	localparam int ENTCW = $clog2(BUF + 1);
	localparam int SBW = (SB > 1) ? $clog2(SB) : 1;
	localparam int EPAW = $clog2(BUF * SB);
	localparam int POSW = $clog2(POS_CAP + 1);

	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [7:0] deg;
		logic [SRC-1:0] mask;
	} ent_t;

	typedef struct packed {
		logic [SRCW-1:0] src;
		logic [ENTW-1:0] ent;
	} rip_t;

	typedef struct packed {
		logic found;
		logic [SRCW-1:0] idx;
	} ffs_t;

	function automatic ffs_t find_first(logic [SRC-1:0] m);
		ffs_t r;
		r.found = 1'b0;
		r.idx = '0;
		for (int s = SRC - 1; s >= 0; s--) begin
			if (m[s]) begin
				r.found = 1'b1;
				r.idx = SRCW'(s);
			end
		end
		return r;
	endfunction

	function automatic logic [EPAW-1:0] pay_addr(logic [ENTW-1:0] e, logic [SBW-1:0] k);
		return EPAW'(32'(e) * SB + 32'(k));
	endfunction

endpackage

@@ rtl/lt_peeling_decoder.sv @@
// Top level of the LT fountain-code peeling decoder.
// Input beats carry mode, packet_byte, last_byte, read_symbol and read_offset.
// Mode 0 beats deliver packet bytes; non-final bytes are taken one per cycle.
// The beat with last_byte set starts decoding and yields one status beat
// (is_read_reply low) once peeling finishes. Mode 1 asks for one recovered byte
// and yields a read reply beat after states S_R1, S_R2, S_R3 and S_PUB. Mode 2
// clears the decoder with no reply. Mode 3 is ignored.
// Decoding is a sequencer over on-chip RAMs for buffered entries, entry payloads,
// the ripple and the source map. Its length depends on the buffer contents:
// a duplicate scan reads and compares one byte at a time (S_DRD, S_DCMP), storing
// a packet copies one payload byte at a time (S_SRD, S_SWR), and every XOR
// reduction walks the payload through S_X1, S_X2 and S_X3, since entry payloads
// share one RAM with one read port. Peeling visits every buffered entry for every new ripple symbol.
// in_stall is high while a packet is decoded or a read is in flight.
// Results sit in an output register; a stalled output beat holds steady and
// the decoder still takes input beats meanwhile. Reset empties the buffer,
// the ripple and the recovered set; no RAM clearing pass is needed.
module lt_peeling_decoder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] packet_byte,
	input  logic last_byte,
	input  logic [5:0] read_symbol,
	input  logic [5:0] read_offset,
	output logic out_valid,
	input  logic out_stall,
	output logic is_read_reply,
	output logic [1:0] packet_status,
	output logic decode_done,
	output logic [6:0] recovered_count,
	output logic read_known,
	output logic [7:0] read_byte
);

	typedef enum logic [4:0] {
		S_IDLE, S_FIN, S_DEC, S_DENT, S_DDEG, S_DRD, S_DCMP, S_STORE, S_SRD, S_SWR,
		S_AFTST, S_NRIP, S_NRD, S_NJOIN, S_WB, S_X1, S_X2, S_X3, S_PEEL, S_PRIP,
		S_PENT, S_PDEG, S_PWB, S_PJOIN, S_R1, S_R2, S_R3, S_PUB
	} state_t;

	state_t state_q;
	logic [lpd_pkg::ENTCW-1:0] fill_q, i_q;
	logic [lpd_pkg::SRCCW-1:0] rfill_q, rdone_q, j_q;
	logic [lpd_pkg::SRC-1:0] flags_q;
	logic [1:0] status_q;
	logic [lpd_pkg::ENTW-1:0] t_q, r_q;
	logic [lpd_pkg::SRCW-1:0] src_q, sym_q;
	logic [lpd_pkg::SBW-1:0] k_q, off_q;
	logic [7:0] rbyte_q, cur_deg_q;
	logic [lpd_pkg::SRC-1:0] cur_mask_q;
	logic red_peel_q, is_read_q, known_q, off_ok_q;
	logic out_valid_q, is_read_reply_q, decode_done_q, read_known_q;
	logic [1:0] packet_status_q;
	logic [6:0] recovered_count_q;
	logic [7:0] read_byte_q;

	logic accept, can_pub, can_join, join_fire, k_last, asm_clr;
	lpd_pkg::ent_t pkt, ent_rd, ent_wd;
	lpd_pkg::rip_t rip_rd, rip_wd;
	lpd_pkg::ffs_t ffs;
	logic [7:0] in_rd, epay_rd, epay_wd;
	logic [lpd_pkg::ENTW-1:0] smap_rd;
	logic [lpd_pkg::EPAW-1:0] epay_ra, epay_wa;
	logic [lpd_pkg::SRCW-1:0] rip_ra;
	logic ent_we, epay_we;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign can_pub = !out_valid_q || !out_stall;
	assign k_last = (32'(k_q) == lpd_pkg::SB - 1);
	assign ffs = lpd_pkg::find_first(cur_mask_q);
	assign can_join = (cur_deg_q == 8'd1) && ffs.found && !flags_q[ffs.idx]
		&& (32'(rfill_q) < lpd_pkg::SRC);
	assign join_fire = can_join && ((state_q == S_AFTST) || (state_q == S_NJOIN)
		|| (state_q == S_PJOIN));
	assign asm_clr = (state_q == S_PUB && can_pub && !is_read_q)
		|| (accept && mode == lpd_pkg::MODE_CLEAR);

	assign ent_we = (state_q == S_STORE) || (state_q == S_WB) || (state_q == S_PWB);
	assign ent_wd.deg = cur_deg_q;
	assign ent_wd.mask = cur_mask_q;
	assign epay_we = (state_q == S_SWR) || (state_q == S_X3);
	assign epay_wa = lpd_pkg::pay_addr(t_q, k_q);
	assign epay_wd = (state_q == S_SWR) ? in_rd : (epay_rd ^ rbyte_q);
	assign rip_ra = (state_q == S_PEEL) ? rdone_q[lpd_pkg::SRCW-1:0] : j_q[lpd_pkg::SRCW-1:0];
	assign rip_wd.src = ffs.idx;
	assign rip_wd.ent = t_q;

	always_comb begin
		case (state_q)
			S_DRD:   epay_ra = lpd_pkg::pay_addr(i_q[lpd_pkg::ENTW-1:0], k_q);
			S_X1:    epay_ra = lpd_pkg::pay_addr(r_q, k_q);
			S_R2:    epay_ra = lpd_pkg::pay_addr(smap_rd, off_q);
			default: epay_ra = lpd_pkg::pay_addr(t_q, k_q);
		endcase
	end

	lpd_asm u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept && mode == lpd_pkg::MODE_BYTE),
		.clr     (asm_clr),
		.data    (packet_byte),
		.rd_addr (k_q),
		.pkt     (pkt),
		.rd_byte (in_rd)
	);

	lpd_ram #(.WIDTH($bits(lpd_pkg::ent_t)), .DEPTH(lpd_pkg::BUF)) u_ent (
		.clk   (clk),
		.we    (ent_we),
		.waddr (t_q),
		.wdata (ent_wd),
		.raddr (i_q[lpd_pkg::ENTW-1:0]),
		.rdata (ent_rd)
	);

	lpd_ram #(.WIDTH(8), .DEPTH(lpd_pkg::BUF * lpd_pkg::SB)) u_epay (
		.clk   (clk),
		.we    (epay_we),
		.waddr (epay_wa),
		.wdata (epay_wd),
		.raddr (epay_ra),
		.rdata (epay_rd)
	);

	lpd_ram #(.WIDTH($bits(lpd_pkg::rip_t)), .DEPTH(lpd_pkg::SRC)) u_rip (
		.clk   (clk),
		.we    (join_fire),
		.waddr (rfill_q[lpd_pkg::SRCW-1:0]),
		.wdata (rip_wd),
		.raddr (rip_ra),
		.rdata (rip_rd)
	);

	lpd_ram #(.WIDTH(lpd_pkg::ENTW), .DEPTH(lpd_pkg::SRC)) u_smap (
		.clk   (clk),
		.we    (join_fire),
		.waddr (ffs.idx),
		.wdata (t_q),
		.raddr (sym_q),
		.rdata (smap_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			rfill_q <= '0;
			rdone_q <= '0;
			flags_q <= '0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			red_peel_q <= 1'b0;
			is_read_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_PUB) begin
				out_valid_q <= 1'b0;
			end
			if (join_fire) begin
				flags_q[ffs.idx] <= 1'b1;
				rfill_q <= rfill_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							lpd_pkg::MODE_BYTE: begin
								if (last_byte) begin
									is_read_q <= 1'b0;
									state_q <= S_FIN;
								end
							end
							lpd_pkg::MODE_READ: begin
								is_read_q <= 1'b1;
								sym_q <= lpd_pkg::SRCW'(read_symbol);
								known_q <= (32'(read_symbol) < lpd_pkg::SRC)
									&& flags_q[lpd_pkg::SRCW'(read_symbol)];
								off_q <= lpd_pkg::SBW'(read_offset);
								off_ok_q <= (32'(read_offset) < lpd_pkg::SB);
								state_q <= S_R1;
							end
							lpd_pkg::MODE_CLEAR: begin
								fill_q <= '0;
								rfill_q <= '0;
								rdone_q <= '0;
								flags_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_FIN: begin
					cur_deg_q <= pkt.deg;
					cur_mask_q <= pkt.mask;
					t_q <= fill_q[lpd_pkg::ENTW-1:0];
					status_q <= lpd_pkg::ST_OK;
					i_q <= '0;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (cur_deg_q == 8'd0) begin
						status_q <= lpd_pkg::ST_DUP;
						state_q <= S_PEEL;
					end else if (cur_deg_q == 8'd1) begin
						if (!ffs.found || flags_q[ffs.idx]) begin
							status_q <= lpd_pkg::ST_DUP;
							state_q <= S_PEEL;
						end else if (32'(fill_q) >= lpd_pkg::BUF) begin
							status_q <= lpd_pkg::ST_FULL;
							state_q <= S_PEEL;
						end else begin
							state_q <= S_STORE;
						end
					end else begin
						state_q <= S_DENT;
					end
				end
				S_DENT: begin
					if (i_q == fill_q) begin
						if (32'(fill_q) >= lpd_pkg::BUF) begin
							status_q <= lpd_pkg::ST_FULL;
							state_q <= S_PEEL;
						end else begin
							state_q <= S_STORE;
						end
					end else begin
						state_q <= S_DDEG;
					end
				end
				S_DDEG: begin
					if (ent_rd.deg == cur_deg_q) begin
						k_q <= '0;
						state_q <= S_DRD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_DENT;
					end
				end
				S_DRD: begin
					state_q <= S_DCMP;
				end
				S_DCMP: begin
					if (epay_rd != in_rd) begin
						i_q <= i_q + 1'b1;
						state_q <= S_DENT;
					end else if (k_last) begin
						status_q <= lpd_pkg::ST_DUP;
						state_q <= S_PEEL;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_STORE: begin
					fill_q <= fill_q + 1'b1;
					k_q <= '0;
					state_q <= S_SRD;
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				S_SWR: begin
					if (k_last) begin
						state_q <= S_AFTST;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_AFTST: begin
					j_q <= '0;
					state_q <= (cur_deg_q == 8'd1) ? S_PEEL : S_NRIP;
				end
				S_NRIP: begin
					state_q <= (j_q == rfill_q) ? S_WB : S_NRD;
				end
				S_NRD: begin
					r_q <= rip_rd.ent;
					src_q <= rip_rd.src;
					if (cur_mask_q[rip_rd.src]) begin
						if (cur_deg_q != 8'd0) begin
							cur_deg_q <= cur_deg_q - 1'b1;
						end
						cur_mask_q[rip_rd.src] <= 1'b0;
						k_q <= '0;
						red_peel_q <= 1'b0;
						state_q <= S_X1;
					end else begin
						state_q <= S_NJOIN;
					end
				end
				S_NJOIN: begin
					if (can_join) begin
						state_q <= S_WB;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_NRIP;
					end
				end
				S_WB: begin
					state_q <= S_PEEL;
				end
				S_X1: begin
					state_q <= S_X2;
				end
				S_X2: begin
					rbyte_q <= epay_rd;
					state_q <= S_X3;
				end
				S_X3: begin
					if (k_last) begin
						state_q <= red_peel_q ? S_PWB : S_NJOIN;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_X1;
					end
				end
				S_PEEL: begin
					if (rdone_q == rfill_q) begin
						state_q <= S_PUB;
					end else begin
						rdone_q <= rdone_q + 1'b1;
						state_q <= S_PRIP;
					end
				end
				S_PRIP: begin
					r_q <= rip_rd.ent;
					src_q <= rip_rd.src;
					i_q <= '0;
					state_q <= S_PENT;
				end
				S_PENT: begin
					state_q <= (i_q == fill_q) ? S_PEEL : S_PDEG;
				end
				S_PDEG: begin
					t_q <= i_q[lpd_pkg::ENTW-1:0];
					if (ent_rd.deg == 8'd0) begin
						cur_deg_q <= ent_rd.deg;
						cur_mask_q <= ent_rd.mask;
						i_q <= i_q + 1'b1;
						state_q <= S_PENT;
					end else if (ent_rd.mask[src_q] && ent_rd.deg != 8'd1) begin
						cur_deg_q <= ent_rd.deg - 1'b1;
						cur_mask_q <= ent_rd.mask
							& ~({{(lpd_pkg::SRC-1){1'b0}}, 1'b1} << src_q);
						k_q <= '0;
						red_peel_q <= 1'b1;
						state_q <= S_X1;
					end else begin
						cur_deg_q <= ent_rd.deg;
						cur_mask_q <= ent_rd.mask;
						state_q <= S_PJOIN;
					end
				end
				S_PWB: begin
					state_q <= S_PJOIN;
				end
				S_PJOIN: begin
					i_q <= i_q + 1'b1;
					state_q <= S_PENT;
				end
				S_R1: begin
					state_q <= S_R2;
				end
				S_R2: begin
					state_q <= S_R3;
				end
				S_R3: begin
					rbyte_q <= (known_q && off_ok_q) ? epay_rd : 8'd0;
					state_q <= S_PUB;
				end
				S_PUB: begin
					if (can_pub) begin
						out_valid_q <= 1'b1;
						is_read_reply_q <= is_read_q;
						packet_status_q <= is_read_q ? lpd_pkg::ST_OK : status_q;
						decode_done_q <= (32'(rfill_q) == lpd_pkg::SRC);
						recovered_count_q <= 7'(rfill_q);
						read_known_q <= is_read_q && known_q;
						read_byte_q <= is_read_q ? rbyte_q : 8'd0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign is_read_reply = is_read_reply_q;
	assign packet_status = packet_status_q;
	assign decode_done = decode_done_q;
	assign recovered_count = recovered_count_q;
	assign read_known = read_known_q;
	assign read_byte = read_byte_q;

`ifndef SYNTHESIS
	a_done_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rdone_q <= rfill_q) else $error("ripple done count passed ripple fill");
	a_ripple_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rfill_q) <= lpd_pkg::SRC) else $error("ripple overflow");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= lpd_pkg::BUF) else $error("entry buffer overflow");
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(flags_q) == 32'(rfill_q)) else $error("recovered flags disagree with ripple");
`endif

endmodule

@@ rtl/lpd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lpd_asm.sv @@
// Packet assembler: byte position, degree, neighbor bitmap and incoming payload.
module lpd_asm (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic clr,
	input  logic [7:0] data,
	input  logic [lpd_pkg::SBW-1:0] rd_addr,
	output lpd_pkg::ent_t pkt,
	output logic [7:0] rd_byte
);

	logic [lpd_pkg::POSW-1:0] pos_q;
	logic [7:0] deg_q;
	logic [lpd_pkg::SRC-1:0] mask_q;
	logic [lpd_pkg::SB-1:0] vld_q;
	logic rd_vld_q;
	logic [7:0] ram_rd;
	logic pay_hit;
	logic [lpd_pkg::SBW-1:0] pay_idx;

	assign pay_hit = (32'(pos_q) >= lpd_pkg::PAY_OFF) && (32'(pos_q) < lpd_pkg::PAY_OFF + lpd_pkg::SB);
	assign pay_idx = lpd_pkg::SBW'(32'(pos_q) - lpd_pkg::PAY_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		int unsigned bidx;
		if (!arst_n) begin
			pos_q <= '0;
			deg_q <= '0;
			mask_q <= '0;
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clr) begin
				pos_q <= '0;
				deg_q <= '0;
				mask_q <= '0;
				vld_q <= '0;
			end else if (wr) begin
				if (32'(pos_q) == lpd_pkg::DEG_OFF) begin
					deg_q <= data;
				end
				if ((32'(pos_q) >= lpd_pkg::MASK_OFF) && (32'(pos_q) < lpd_pkg::PAY_OFF)) begin
					for (int m = 0; m < 8; m++) begin
						bidx = (32'(pos_q) - lpd_pkg::MASK_OFF) * 8 + 32'(m);
						if (bidx < lpd_pkg::SRC) begin
							mask_q[lpd_pkg::SRCW'(bidx)] <= data[m];
						end
					end
				end
				if (pay_hit) begin
					vld_q[pay_idx] <= 1'b1;
				end
				if (32'(pos_q) < lpd_pkg::POS_CAP) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	lpd_ram #(.WIDTH(8), .DEPTH(lpd_pkg::SB)) u_inpay (
		.clk   (clk),
		.we    (wr && !clr && pay_hit),
		.waddr (pay_idx),
		.wdata (data),
		.raddr (rd_addr),
		.rdata (ram_rd)
	);

	assign pkt.deg = deg_q;
	assign pkt.mask = mask_q;
	assign rd_byte = rd_vld_q ? ram_rd : 8'd0;

endmodule
